// ===== sv/tanh_pkg.sv =====
package tanh_pkg;

	localparam int NUM_TERMS = 7;
	localparam int DEN_TERMS = 4;
	localparam int HORNER_CELLS = NUM_TERMS - 1;
	// one quotient bit per cell: 24 mantissa bits and a guard bit
	localparam int QUO_BITS = 25;

	// decimal constants go through binary64 at elaboration and are rounded here
	function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
		logic [7:0]  e32;
		logic [22:0] fr;
		logic        g;
		logic        st;
		logic        up;
		e32 = 8'(d[62:52] - 11'd896);
		fr  = d[51:29];
		g   = d[28];
		st  = |d[27:0];
		up  = g & (st | fr[0]);
		return {d[63], 31'({e32, fr} + 31'(up))};
	endfunction

	localparam logic [31:0] NUM_COEF [NUM_TERMS] = '{
		f64_to_f32($realtobits(-2.76076847742355e-16)),
		f64_to_f32($realtobits(2.00018790482477e-13)),
		f64_to_f32($realtobits(-8.60467152213735e-11)),
		f64_to_f32($realtobits(5.12229709037114e-08)),
		f64_to_f32($realtobits(1.48572235717979e-05)),
		f64_to_f32($realtobits(6.37261928875436e-04)),
		f64_to_f32($realtobits(4.89352455891786e-03))
	};
	localparam logic [31:0] DEN_COEF [DEN_TERMS] = '{
		f64_to_f32($realtobits(1.19825839466702e-06)),
		f64_to_f32($realtobits(1.18534705686654e-04)),
		f64_to_f32($realtobits(2.26843463243900e-03)),
		f64_to_f32($realtobits(4.89352518554385e-03))
	};
	localparam logic [31:0] F32_TINY  = f64_to_f32($realtobits(0.0004));
	localparam logic [31:0] F32_CLAMP = f64_to_f32($realtobits(7.90531110763549805));
	localparam logic [31:0] F32_ONE   = 32'h3F80_0000;
	localparam logic [15:0] F16_ONE   = 16'h3C00;
	localparam logic [30:0] F32_INF   = 31'h7F80_0000;

	typedef struct packed {
		logic        half;
		logic        use_core;
		logic [31:0] fixed;
	} side_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] s;
		logic [31:0] num;
		logic [31:0] den;
		side_t       side;
	} hor_t;

	typedef struct packed {
		logic        sign;
		logic [9:0]  exp;
		logic [27:0] sum;
	} addp_t;

	typedef struct packed {
		logic                sign;
		logic [9:0]          exp;
		logic [QUO_BITS-1:0] rem;
		logic [QUO_BITS-1:0] q;
		logic [23:0]         md;
		side_t               side;
	} div_t;

	// binary32 multiply, round to nearest even; tiny operands read as zero
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic [47:0] p;
		logic [9:0]  e;
		logic [22:0] fr;
		logic        g;
		logic        st;
		logic        up;
		logic [30:0] r;
		logic        sgn;
		sgn = a[31] ^ b[31];
		p = 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
		e = {2'b0, a[30:23]} + {2'b0, b[30:23]} - 10'd127 + {9'b0, p[47]};
		if (p[47]) begin
			fr = p[46:24];
			g  = p[23];
			st = |p[22:0];
		end else begin
			fr = p[45:23];
			g  = p[22];
			st = |p[21:0];
		end
		up = g & (st | fr[0]);
		r  = {e[7:0], fr} + 31'(up);
		if (a[30:23] == 8'd0 || b[30:23] == 8'd0 || e[9] || e == 10'd0)
			return {sgn, 31'd0};
		else if (e[8:0] >= 9'd255)
			return {sgn, F32_INF};
		else
			return {sgn, r};
	endfunction

	// add, first half: order by magnitude, align with sticky, add or subtract
	function automatic addp_t fadd_pre(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] big;
		logic [31:0] lit;
		logic [7:0]  d;
		logic [26:0] ma;
		logic [26:0] mb;
		logic [26:0] bs;
		logic [26:0] mask;
		logic        st;
		addp_t       r;
		if (b[30:0] > a[30:0]) begin
			big = b;
			lit = a;
		end else begin
			big = a;
			lit = b;
		end
		ma = (big[30:23] == 8'd0) ? 27'd0 : {1'b1, big[22:0], 3'b0};
		mb = (lit[30:23] == 8'd0) ? 27'd0 : {1'b1, lit[22:0], 3'b0};
		d  = big[30:23] - lit[30:23];
		if (d >= 8'd27) begin
			bs = 27'd0;
			st = |mb;
		end else begin
			mask = (27'd1 << d[4:0]) - 27'd1;
			bs   = mb >> d[4:0];
			st   = |(mb & mask);
		end
		bs[0] = bs[0] | st;
		r.sign = big[31];
		r.exp  = {2'b0, big[30:23]};
		if (big[31] ^ lit[31])
			r.sum = {1'b0, ma} - {1'b0, bs};
		else
			r.sum = {1'b0, ma} + {1'b0, bs};
		if (big[31] && lit[31] == 1'b0 && big[30:0] == 31'd0)
			r.sign = 1'b0;
		return r;
	endfunction

	// add, second half: normalize and round to nearest even
	function automatic logic [31:0] fadd_post(input addp_t p);
		logic [26:0] m;
		logic [4:0]  lz;
		logic        found;
		logic [9:0]  e;
		logic        g;
		logic        st;
		logic        up;
		logic [30:0] r;
		lz    = 5'd0;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found) begin
				if (p.sum[i])
					found = 1'b1;
				else
					lz = lz + 5'd1;
			end
		end
		if (p.sum[27]) begin
			m = {p.sum[27:2], p.sum[1] | p.sum[0]};
			e = p.exp + 10'd1;
		end else begin
			m = p.sum[26:0] << lz;
			e = p.exp - {5'b0, lz};
		end
		g  = m[2];
		st = m[1] | m[0];
		up = g & (st | m[3]);
		r  = {e[7:0], m[25:3]} + 31'(up);
		if (p.sum == 28'd0)
			return 32'd0;
		else if (e[9] || e == 10'd0)
			return {p.sign, 31'd0};
		else if (e[8:0] >= 9'd255)
			return {p.sign, F32_INF};
		else
			return {p.sign, r};
	endfunction

	// binary32 to binary16 for results in the normal binary16 range
	function automatic logic [15:0] narrow_half(input logic [31:0] f);
		logic [14:0] r;
		logic [12:0] rem;
		logic        up;
		r   = {5'(f[30:23] - 8'd112), f[22:13]};
		rem = f[12:0];
		up  = (rem > 13'h1000) || (rem == 13'h1000 && r[0]);
		return {f[31], 15'(r + 15'(up))};
	endfunction

endpackage

// ===== sv/tanh_ifs.sv =====
interface tanh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_bits;
	modport source (output valid, output x_bits, input ready);
	modport sink (input valid, input x_bits, output ready);
endinterface

interface tanh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] y_bits;
	modport source (output valid, output y_bits, input ready);
	modport sink (input valid, input y_bits, output ready);
endinterface

// ===== sv/tanh_horner_cell.sv =====
// One Horner step on the numerator, and on the denominator when den_on is set: multiply, align/add, normalize/round.
module tanh_horner_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [31:0]      coef_n,
	input  logic [31:0]      coef_d,
	input  logic             den_on,
	input  logic             v_in,
	input  tanh_pkg::hor_t   d_in,
	output logic             v_out,
	output tanh_pkg::hor_t   d_out
);

	logic              v_s1;
	logic              v_s2;
	tanh_pkg::hor_t    d_s1;
	tanh_pkg::hor_t    d_s2;
	logic [31:0]       tn_s1;
	logic [31:0]       td_s1;
	tanh_pkg::addp_t   pn_s2;
	tanh_pkg::addp_t   pd_s2;
	tanh_pkg::hor_t    d_nxt;

	always_comb begin
		d_nxt     = d_s2;
		d_nxt.num = tanh_pkg::fadd_post(pn_s2);
		if (den_on)
			d_nxt.den = tanh_pkg::fadd_post(pd_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_out <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= d_in;
			tn_s1 <= tanh_pkg::fmul(d_in.s, d_in.num);
			td_s1 <= tanh_pkg::fmul(d_in.s, d_in.den);
			d_s2  <= d_s1;
			pn_s2 <= tanh_pkg::fadd_pre(tn_s1, coef_n);
			pd_s2 <= tanh_pkg::fadd_pre(td_s1, coef_d);
			d_out <= d_nxt;
		end
	end

endmodule

// ===== sv/tanh_div_cell.sv =====
// One restoring division step: one quotient bit per cell.
module tanh_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  tanh_pkg::div_t  d_in,
	output logic            v_out,
	output tanh_pkg::div_t  d_out
);

	logic [tanh_pkg::QUO_BITS-1:0] diff;
	logic                          ge;
	tanh_pkg::div_t                d_nxt;

	always_comb begin
		diff  = d_in.rem - {1'b0, d_in.md};
		ge    = d_in.rem >= {1'b0, d_in.md};
		d_nxt = d_in;
		d_nxt.q = {d_in.q[tanh_pkg::QUO_BITS-2:0], ge};
		if (ge)
			d_nxt.rem = {diff[tanh_pkg::QUO_BITS-2:0], 1'b0};
		else
			d_nxt.rem = {d_in.rem[tanh_pkg::QUO_BITS-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out <= 1'b0;
		else if (en)
			v_out <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= d_nxt;
	end

endmodule

// ===== sv/tanh_rational_approx_f32_top.sv =====
// tanh by rational approximation, binary32 (or binary16 with half_mode set).
// Fully pipelined: one item per cycle while x_in.ready is high. The stages are
// the input register, the squaring stage, six Horner cells of three stages each,
// the x*num multiply, the divider setup stage, 25 restoring divider cells (one
// quotient bit per cell) and the rounding stage. A two-entry output buffer
// decouples y_out backpressure from x_in.ready; the pipeline stalls as a whole
// only when both entries are full. half_mode must be written while no item is in
// flight.
module tanh_rational_approx_f32_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	tanh_in_if.sink           x_in,
	tanh_out_if.source        y_out
);

	localparam int HC = tanh_pkg::HORNER_CELLS;
	localparam int QB = tanh_pkg::QUO_BITS;

	logic              half_q;
	logic              en;

	// entry
	logic [15:0]       h;
	logic [31:0]       wide;
	logic [31:0]       x32;
	tanh_pkg::side_t   side_in;
	logic              v_s1;
	logic [31:0]       x_s1;
	tanh_pkg::side_t   side_s1;

	// Horner chain
	logic              hor_v [HC+1];
	tanh_pkg::hor_t    hor_d [HC+1];

	// x * num, divide setup
	logic              v_s21;
	tanh_pkg::hor_t    d_s21;
	logic [23:0]       mn;
	logic [23:0]       md;
	logic              lt;
	tanh_pkg::div_t    div_in;

	logic              div_v [QB+1];
	tanh_pkg::div_t    div_d [QB+1];

	// rounding and output
	logic              v_s48;
	logic [31:0]       q_s48;
	tanh_pkg::side_t   side_s48;
	tanh_pkg::div_t    dl;
	logic              up;
	logic [31:0]       y_nxt;
	logic              push;
	logic              out_v_q;
	logic [31:0]       out_d_q;
	logic              skid_v_q;
	logic [31:0]       skid_d_q;

	assign en          = !skid_v_q;
	assign x_in.ready  = en;
	assign y_out.valid = out_v_q;
	assign y_out.y_bits = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			half_q <= 1'b0;
		else if (cfg_we)
			half_q <= cfg_wdata;
	end

	// classify the operand; anything not handled by the core gets its final value now
	always_comb begin
		h = x_in.x_bits[15:0];
		if (h[14:10] == 5'h1F)
			wide = {h[15], 8'hFF, 23'd0};
		else
			wide = {h[15], 8'({3'b0, h[14:10]} + 8'd112), h[9:0], 13'd0};
		x32 = half_q ? wide : x_in.x_bits;
		side_in.half     = half_q;
		side_in.use_core = 1'b0;
		side_in.fixed    = x_in.x_bits;
		if (half_q) begin
			priority if (h[14:10] == 5'h1F && h[9:0] != 10'd0) begin
				side_in.fixed = {16'd0, h};
			end else if (h[14:10] == 5'd0 || x32[30:0] < tanh_pkg::F32_TINY[30:0]) begin
				side_in.fixed = {16'd0, h};
			end else if (x32[30:0] > tanh_pkg::F32_CLAMP[30:0]) begin
				side_in.fixed = {16'd0, h[15], tanh_pkg::F16_ONE[14:0]};
			end else begin
				side_in.use_core = 1'b1;
			end
		end else begin
			priority if (x32[30:0] > tanh_pkg::F32_INF) begin
				side_in.fixed = x32;
			end else if (x32[30:0] < tanh_pkg::F32_TINY[30:0]) begin
				side_in.fixed = x32;
			end else if (x32[30:0] > tanh_pkg::F32_CLAMP[30:0]) begin
				side_in.fixed = {x32[31], tanh_pkg::F32_ONE[30:0]};
			end else begin
				side_in.use_core = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			hor_v[0] <= 1'b0;
		end else if (en) begin
			v_s1     <= x_in.valid;
			hor_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1         <= x32;
			side_s1      <= side_in;
			hor_d[0].x   <= x_s1;
			hor_d[0].s   <= tanh_pkg::fmul(x_s1, x_s1);
			hor_d[0].num <= tanh_pkg::NUM_COEF[0];
			hor_d[0].den <= tanh_pkg::DEN_COEF[0];
			hor_d[0].side <= side_s1;
		end
	end

	for (genvar k = 0; k < HC; k++) begin : g_horner
		logic [31:0] cd;
		logic        don;
		if (k < tanh_pkg::DEN_TERMS - 1) begin : g_den
			assign cd  = tanh_pkg::DEN_COEF[k+1];
			assign don = 1'b1;
		end else begin : g_num_only
			assign cd  = 32'd0;
			assign don = 1'b0;
		end
		tanh_horner_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.coef_n (tanh_pkg::NUM_COEF[k+1]),
			.coef_d (cd),
			.den_on (don),
			.v_in   (hor_v[k]),
			.d_in   (hor_d[k]),
			.v_out  (hor_v[k+1]),
			.d_out  (hor_d[k+1])
		);
	end

	// divide setup: quotient mantissa in [1,2) by pre-shifting the dividend
	always_comb begin
		mn = {1'b1, d_s21.num[22:0]};
		md = {1'b1, d_s21.den[22:0]};
		lt = mn < md;
		div_in.sign = d_s21.num[31] ^ d_s21.den[31];
		div_in.exp  = {2'b0, d_s21.num[30:23]} - {2'b0, d_s21.den[30:23]} + 10'd127
			- {9'd0, lt};
		div_in.rem  = lt ? {mn, 1'b0} : {1'b0, mn};
		div_in.q    = '0;
		div_in.md   = md;
		div_in.side = d_s21.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s21    <= 1'b0;
			div_v[0] <= 1'b0;
		end else if (en) begin
			v_s21    <= hor_v[HC];
			div_v[0] <= v_s21;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s21.x    <= hor_d[HC].x;
			d_s21.s    <= hor_d[HC].s;
			d_s21.num  <= tanh_pkg::fmul(hor_d[HC].x, hor_d[HC].num);
			d_s21.den  <= hor_d[HC].den;
			d_s21.side <= hor_d[HC].side;
			div_d[0]   <= div_in;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		tanh_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (div_v[k]),
			.d_in   (div_d[k]),
			.v_out  (div_v[k+1]),
			.d_out  (div_d[k+1])
		);
	end

	// round the quotient: q[QB-1] is the leading one, q[0] the guard bit
	always_comb begin
		dl = div_d[QB];
		up = dl.q[0] & ((dl.rem != '0) | dl.q[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s48 <= 1'b0;
		else if (en)
			v_s48 <= div_v[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s48    <= {dl.sign, 31'({dl.exp[7:0], dl.q[QB-2:1]} + 31'(up))};
			side_s48 <= dl.side;
		end
	end

	always_comb begin
		if (!side_s48.use_core)
			y_nxt = side_s48.fixed;
		else if (side_s48.half)
			y_nxt = {16'd0, tanh_pkg::narrow_half(q_s48)};
		else
			y_nxt = q_s48;
	end

	assign push = en & v_s48;

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (y_out.ready || !out_v_q) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (y_out.ready || !out_v_q) begin
			out_d_q <= skid_v_q ? skid_d_q : y_nxt;
		end else if (push) begin
			skid_d_q <= y_nxt;
		end
	end

endmodule

// ===== sv/tanh_checker.sv =====
module tanh_checker (
	input  logic        clk,
	input  logic        arst_n,
	tanh_in_if.sink     x_in,
	tanh_out_if.source  y_out
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		y_out.valid && !y_out.ready |=> y_out.valid && $stable(y_out.y_bits))
		else $error("result changed or dropped while stalled");

	// input is only held off while a result waits at the output
	a_ready_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!x_in.ready |-> y_out.valid)
		else $error("input stalled with empty output");

	// the skid entry fills only when the output was full and not taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(x_in.ready) |-> $past(y_out.valid && !y_out.ready))
		else $error("input stalled without output backpressure");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !y_out.valid)
		else $error("result valid during reset");

endmodule

bind tanh_rational_approx_f32_top tanh_checker u_tanh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.x_in   (x_in),
	.y_out  (y_out)
);

// ===== tb/tanh_tb_ifs.sv =====
interface tanh_cfg_if;
	logic we;
	logic wdata;
	modport source (output we, output wdata);
	modport sink (input we, input wdata);
endinterface

// ===== tb/tb_top.sv =====
module tb_top;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [31:0] POS_ONE = 32'h3F80_0000;
	localparam logic [31:0] NEG_ONE = 32'hBF80_0000;

	logic clk;
	logic arst_n;

	tanh_cfg_if cfg_if ();
	tanh_in_if  in_if ();
	tanh_out_if out_if ();

	tanh_rational_approx_f32_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_if.we),
		.cfg_wdata (cfg_if.wdata),
		.x_in      (in_if),
		.y_out     (out_if)
	);

	logic [31:0] y_expected[$];
	logic        half_sel;
	int          err_count;
	int          snd_idle_pct;
	int          rcv_idle_pct;
	int          rcv_hold;
	int          quiet_cycles;

	// binary32 rounding of a double, normal range only (all the core ever needs)
	function automatic logic [31:0] to_single(real v);
		logic [63:0] d;
		logic        up;
		if (v == 0.0)
			return 32'd0;
		d  = $realtobits(v);
		up = d[28] & ((|d[27:0]) | d[29]);
		return {d[63], 31'({8'(d[62:52] - 11'd896), d[51:29]} + 31'(up))};
	endfunction

	function automatic real from_single(logic [31:0] b);
		if (b[30:0] == 31'd0)
			return 0.0;
		return $bitstoreal({b[31], 11'({3'b0, b[30:23]} + 11'd896), b[22:0], 29'd0});
	endfunction

	// products and quotients of binary32 values are rounded correctly through a double
	function automatic real rnd(real v);
		return from_single(to_single(v));
	endfunction

	function automatic logic [31:0] tanh_single(logic [31:0] x);
		real num_k [7];
		real den_k [4];
		real xr;
		real s;
		real num;
		real den;
		real lim;
		num_k = '{-2.76076847742355e-16, 2.00018790482477e-13, -8.60467152213735e-11,
			5.12229709037114e-08, 1.48572235717979e-05, 6.37261928875436e-04,
			4.89352455891786e-03};
		den_k = '{1.19825839466702e-06, 1.18534705686654e-04, 2.26843463243900e-03,
			4.89352518554385e-03};
		if (x[30:23] == 8'hFF)
			return x[31] ? NEG_ONE : POS_ONE;
		if (x[30:23] == 8'd0)
			return x;
		xr  = from_single(x);
		lim = rnd(7.90531110763549805);
		if (xr > lim)
			return POS_ONE;
		if (xr < -lim)
			return NEG_ONE;
		if ((xr < 0.0 ? -xr : xr) < rnd(0.0004))
			return x;
		s   = rnd(xr * xr);
		num = rnd(num_k[0]);
		for (int i = 1; i < 7; i++)
			num = rnd(rnd(s * num) + rnd(num_k[i]));
		num = rnd(xr * num);
		den = rnd(den_k[0]);
		for (int i = 1; i < 4; i++)
			den = rnd(rnd(s * den) + rnd(den_k[i]));
		return to_single(num / den);
	endfunction

	function automatic logic [31:0] half_to_single(logic [15:0] h);
		logic [10:0] m;
		logic [7:0]  ef;
		m = {1'b0, h[9:0]};
		if (h[14:10] == 5'h1F)
			return {h[15], 8'hFF, h[9:0], 13'd0};
		if (h[14:10] == 5'd0) begin
			if (m == 11'd0)
				return {h[15], 31'd0};
			ef = 8'd113;
			while (!m[10]) begin
				m  = m << 1;
				ef = ef - 8'd1;
			end
			return {h[15], ef, m[9:0], 13'd0};
		end
		return {h[15], 8'({3'b0, h[14:10]} + 8'd112), h[9:0], 13'd0};
	endfunction

	function automatic logic [15:0] single_to_half(logic [31:0] f);
		int unsigned m;
		int unsigned r;
		int unsigned rem;
		int unsigned hlf;
		int unsigned sh;
		int          eh;
		m = f[22:0];
		if (f[30:23] == 8'hFF) begin
			if (m == 0)
				return {f[31], 15'h7C00};
			r = m >> 13;
			if (r == 0)
				r = 32'h200;
			return {f[31], 15'h7C00 | 15'(r)};
		end
		if (f[30:23] == 8'd0)
			return {f[31], 15'd0};
		eh = int'(f[30:23]) - 112;
		if (eh >= 31)
			return {f[31], 15'h7C00};
		if (eh <= 0) begin
			m  = m | 32'h80_0000;
			sh = 14 - eh;
			if (sh >= 25)
				return {f[31], 15'd0};
			r   = m >> sh;
			rem = m & ((32'd1 << sh) - 1);
			hlf = 32'd1 << (sh - 1);
		end else begin
			r   = (eh << 10) | (m >> 13);
			rem = m & 32'h1FFF;
			hlf = 32'h1000;
		end
		if (rem > hlf || (rem == hlf && r[0]))
			r = r + 1;
		return {f[31], 15'(r)};
	endfunction

	function automatic logic [31:0] tanh_predict(logic [31:0] x);
		logic [31:0] w;
		if (half_sel) begin
			w = half_to_single(x[15:0]);
			if (w[30:0] > tanh_pkg::F32_INF)
				return {16'd0, x[15:0]};
			return {16'd0, single_to_half(tanh_single(w))};
		end
		if (x[30:0] > tanh_pkg::F32_INF)
			return x;
		return tanh_single(x);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: %s got %08h want %08h", what, got, want);
		err_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls, or a counted hold-off
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rcv_hold > 0) begin
				out_if.ready = 1'b0;
				rcv_hold--;
			end else
				out_if.ready = ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (out_if.valid && out_if.ready) begin
			if (y_expected.size() == 0)
				report_mismatch("unexpected item y_bits", out_if.y_bits, 32'd0);
			else if (out_if.y_bits !== y_expected[0])
				report_mismatch("y_bits", out_if.y_bits, y_expected.pop_front());
			else
				void'(y_expected.pop_front());
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles = 0;
		else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_x(logic [31:0] x);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_if.valid = 1'b0;
			@(negedge clk);
		end
		in_if.valid  = 1'b1;
		in_if.x_bits = x;
		do
			@(posedge clk);
		while (!in_if.ready);
		y_expected.insert(y_expected.size(), tanh_predict(x));
		@(negedge clk);
	endtask

	task automatic drain();
		in_if.valid = 1'b0;
		while (y_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_half_mode(logic v);
		drain();
		cfg_if.we    = 1'b1;
		cfg_if.wdata = v;
		@(negedge clk);
		cfg_if.we    = 1'b0;
		half_sel     = v;
	endtask

	function automatic logic [31:0] rand_single();
		int pick;
		pick = $urandom_range(9);
		if (pick < 7)  // mostly the rational core range
			return {1'($urandom), 8'($urandom_range(112, 129)), 23'($urandom)};
		if (pick < 9)
			return {1'($urandom), 8'($urandom_range(105, 130)), 23'($urandom)};
		return $urandom;
	endfunction

	function automatic logic [31:0] rand_half();
		int pick;
		pick = $urandom_range(9);
		if (pick < 7)
			return {16'($urandom), 1'($urandom), 5'($urandom_range(5, 17)), 10'($urandom)};
		return $urandom;
	endfunction

	task automatic test_directed_single();
		logic [31:0] lim;
		logic [31:0] tiny;
		logic [31:0] vals [23];
		lim  = to_single(7.90531110763549805);
		tiny = to_single(0.0004);
		vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
			32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFC0_0001, 32'h7F80_0001, 32'h3F80_0000,
			32'hBF80_0000, lim, lim + 32'd1, lim - 32'd1, lim | 32'h8000_0000,
			(lim + 32'd1) | 32'h8000_0000, tiny, tiny - 32'd1, tiny | 32'h8000_0000,
			32'h3E80_0000, 32'hC0A0_0000};
		set_half_mode(1'b0);
		foreach (vals[i])
			send_x(vals[i]);
	endtask

	task automatic test_directed_half();
		logic [31:0] vals [20];
		vals = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_83FF,
			32'h0000_7BFF, 32'h0000_FBFF, 32'h0000_7C00, 32'h0000_FC00,
			32'h0000_7E00, 32'h0000_FD01, 32'h0000_7C01, 32'h0000_3C00,
			32'h0000_BC00, 32'h0000_47E8, 32'h0000_C7E9, 32'h0000_0E8F,
			32'h0000_8E90, 32'hFFFF_3400, 32'hA5A5_B800, 32'h5A5A_4000};
		set_half_mode(1'b1);
		foreach (vals[i])
			send_x(vals[i]);
	endtask

	task automatic test_random(int n, logic half);
		set_half_mode(half);
		repeat (n)
			send_x(half ? rand_half() : rand_single());
	endtask

	// stall the output long enough that the pipeline and its buffer back up
	task automatic test_output_hold();
		snd_idle_pct = 0;
		rcv_hold     = 250;
		repeat (120)
			send_x(rand_single());
	endtask

	task automatic test_pause_until_empty();
		repeat (40)
			send_x(rand_half());
		in_if.valid = 1'b0;
		while (y_expected.size() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (40)
			send_x(rand_half());
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_if.we    = 1'b0;
		cfg_if.wdata = 1'b0;
		in_if.valid  = 1'b0;
		in_if.x_bits = 32'd0;
		half_sel     = 1'b0;
		err_count    = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		rcv_hold     = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		snd_idle_pct = 28;
		rcv_idle_pct = 70;
		test_directed_single();
		test_directed_half();
		test_random(300, 1'b0);
		test_random(300, 1'b1);

		snd_idle_pct = 70;
		rcv_idle_pct = 28;
		test_random(300, 1'b0);
		test_random(300, 1'b1);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random(250, 1'b1);
		test_pause_until_empty();
		test_random(250, 1'b0);
		test_output_hold();
		set_half_mode(1'b0);

		drain();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/tanh_pkg.sv
sv/tanh_ifs.sv
sv/tanh_horner_cell.sv
sv/tanh_div_cell.sv
sv/tanh_rational_approx_f32_top.sv
sv/tanh_checker.sv
tb/tanh_tb_ifs.sv
tb/tb_top.sv
